>>> rtl/core/sbb_pkg.sv
package sbb_pkg;

   localparam int DEF_MAX_RADIUS = 8;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int TAP_LIMIT = 17;
   localparam int ROW_LIMIT = 9;
   localparam int SLOT_W    = 4;
   localparam int COORD_W   = 14;
   localparam int PIX_W     = 24;
   localparam int COEF_W    = 14;
   localparam int PROD_W    = 22;
   localparam int SUM_W     = 24;
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 8;
   localparam int LEVEL_W   = $clog2(OUT_DEPTH + 1);

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [3:0]  radius;
      logic [11:0] width;
      logic [12:0] height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]     pixel;
      logic                 have_h;
      logic                 emit;
      logic                 last;
      logic [COORD_W-1:0]   hx;
      logic [SLOT_W-1:0]    slot;
      logic [TAP_LIMIT-1:0] hmask;
      logic [TAP_LIMIT-1:0] vmask;
   } cmd_type;

   typedef struct packed {
      logic       frame_last;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } res_type;

   typedef logic [TAP_LIMIT*COEF_W-1:0] coef_row_type;

   function automatic coef_row_type pascal_row(input int n);
      int c [TAP_LIMIT];
      int i;
      int k;
      coef_row_type row;
      for (k = 0; k < TAP_LIMIT; k++) c[k] = 0;
      c[0] = 1;
      for (i = 1; i <= n; i++) begin
         for (k = i; k > 0; k--) c[k] = c[k] + c[k-1];
      end
      row = '0;
      for (k = 0; k < TAP_LIMIT; k++) row[k*COEF_W +: COEF_W] = COEF_W'(c[k]);
      return row;
   endfunction

   localparam coef_row_type COEF_ROWS [ROW_LIMIT] = '{
      pascal_row(0), pascal_row(2), pascal_row(4), pascal_row(6), pascal_row(8),
      pascal_row(10), pascal_row(12), pascal_row(14), pascal_row(16)
   };

endpackage

>>> rtl/core/separable_binomial_blur_unit.sv
// Separable binomial blur over an RGB pixel stream in raster order.
// The request channel is a queue input: an item transfers when req_push is high
// and req_full is low. Opcode zero carries a pixel; opcode one is a drain item that
// flushes the last rows after a frame, and r*W+r drains follow the last pixel.
// The response channel is a queue output: the oldest result is on the rsp_ ports
// while rsp_empty is low, and it transfers when rsp_pop is high.
// The control port sets radius, image width and image height at byte addresses 0,
// 4 and 8; the user must write it only while the block is idle; no logic checks it.
// Throughput is one item per clock while the response queue has room. Output
// pixel e is produced by stream item e + r*W + r; that result passes through the
// command queue and the four stage multiply and sum pipeline to the response queue.
// When the receiver stalls, the response queue fills, the back end stops taking
// commands, the command queue fills and req_full rises; nothing is lost.
// Reset clears the counters and queues and loads radius 5, width 1024, height 768.
// The line store holds undefined data after reset and needs no clearing pass.
module separable_binomial_blur_unit
   import sbb_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_frame_last
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RES_W = $bits(res_type);

   logic [3:0]  radius_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   cfg_type     cfg;
   logic        csr_write;

   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type            cmd_in, cmd_out;
   logic [CMD_W-1:0]   cmd_vec;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;
   logic               out_push, out_full;
   res_type            out_data, rsp_data;
   logic [RES_W-1:0]   rsp_vec;
   logic [LEVEL_W-1:0] out_level;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd5;
         width_ff  <= 12'd1024;
         height_ff <= 13'd768;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_RADIUS: radius_ff <= csr_pwdata[3:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[11:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_RADIUS: csr_prdata = 32'(radius_ff);
         REG_WIDTH:  csr_prdata = 32'(width_ff);
         REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:    csr_prdata = '0;
      endcase
      cfg.radius = (radius_ff > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         cfg.width = 12'd1;
      end else if (14'(width_ff) > 14'(MAX_WIDTH)) begin
         cfg.width = 12'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = 13'd1;
      end else if (14'(height_ff) > 14'(MAX_HEIGHT)) begin
         cfg.height = 13'(MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
   end

   sbb_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_opcode   (req_opcode),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .cmd_push     (cmd_push),
      .cmd          (cmd_in),
      .cmd_full     (cmd_full)
   );

   sbb_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_vec),
      .empty (cmd_empty),
      .level (cmd_level)
   );

   assign cmd_out = cmd_type'(cmd_vec);

   sbb_back #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .out_level (out_level),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   sbb_queue #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_vec),
      .empty (rsp_empty),
      .level (out_level)
   );

   always_comb begin
      rsp_data       = res_type'(rsp_vec);
      rsp_red_out    = rsp_data.red;
      rsp_green_out  = rsp_data.green;
      rsp_blue_out   = rsp_data.blue;
      rsp_frame_last = rsp_data.frame_last;
   end

`ifndef ASSERT_OFF
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("response transfer lost on a full queue");
   a_cmd_room: assert property (@(posedge clock) disable iff (reset)
      (cmd_level == '0) |-> cmd_empty)
      else $error("command queue level and empty flag disagree");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full) |-> !cmd_push)
      else $error("command pushed while request stalled");
`endif

endmodule

>>> rtl/core/sbb_queue.sv
module sbb_queue
   import sbb_pkg::*;
#(
   parameter int WIDTH = PIX_W,
   parameter int DEPTH = CMD_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           din,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           dout,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (level_ff == LW'(DEPTH));
      empty   = (level_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      head_in = head_ff;
      tail_in = tail_ff;
      if (do_pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (do_push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
      end
      level_in = level_ff + LW'(do_push) - LW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= din;
      end
   end

   assign dout  = mem_ff[head_ff];
   assign level = level_ff;

endmodule

>>> rtl/core/sbb_front.sv
module sbb_front
   import sbb_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_opcode,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       cmd_push,
   output cmd_type    cmd,
   input  logic       cmd_full
);

   localparam int SLOTS = 2 * MAX_RADIUS;

   logic [11:0]        col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in, hx_ff, hx_in, hy_ff, hy_in;
   logic [3:0]         pre_ff, pre_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               accept, ignore, pixel_ok, started, have_h, do_v, over, emit, last;
   logic [COORD_W-1:0] r_ext, w_ext, h_ext, vy, hxr;
   logic [4:0]         two_r;

   always_comb begin
      r_ext    = COORD_W'(cfg.radius);
      w_ext    = COORD_W'(cfg.width);
      h_ext    = COORD_W'(cfg.height);
      two_r    = {1'b0, cfg.radius} << 1;
      accept   = req_push && !cmd_full;
      ignore   = (req_opcode == OP_DRAIN) && (col_ff == '0) && (row_ff == '0);
      pixel_ok = (req_opcode == OP_PIXEL) && (row_ff < h_ext);
      started  = (pre_ff == cfg.radius);
      have_h   = started && (hy_ff < h_ext);
      do_v     = started && (hy_ff >= r_ext);
      vy       = hy_ff - r_ext;
      over     = do_v && (vy >= h_ext);
      emit     = do_v && !over;
      last     = emit && (vy == h_ext - COORD_W'(1)) && (hx_ff == w_ext - COORD_W'(1));
      hxr      = hx_ff + r_ext;

      col_in  = col_ff;
      row_in  = row_ff;
      pre_in  = pre_ff;
      hx_in   = hx_ff;
      hy_in   = hy_ff;
      slot_in = slot_ff;
      if (accept && !ignore) begin
         if ((13'(col_ff) + 13'd1) >= 13'(cfg.width)) begin
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = col_ff + 12'd1;
         end
         if (!started) begin
            pre_in = pre_ff + 4'd1;
         end else if ((hx_ff + COORD_W'(1)) >= w_ext) begin
            hx_in   = '0;
            hy_in   = hy_ff + COORD_W'(1);
            slot_in = (slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end else begin
            hx_in = hx_ff + COORD_W'(1);
         end
         if (over || last) begin
            col_in  = '0;
            row_in  = '0;
            pre_in  = '0;
            hx_in   = '0;
            hy_in   = '0;
            slot_in = '0;
         end
      end

      cmd.pixel  = pixel_ok ? {req_blue_in, req_green_in, req_red_in} : '0;
      cmd.have_h = have_h && !over;
      cmd.emit   = emit;
      cmd.last   = last;
      cmd.hx     = hx_ff;
      cmd.slot   = slot_ff;
      for (int d = 0; d < TAP_LIMIT; d++) begin
         cmd.hmask[d] = (5'(d) <= two_r) && (hxr >= COORD_W'(d))
                        && ((hxr - COORD_W'(d)) < w_ext);
         cmd.vmask[d] = (5'(d) <= two_r) && (hy_ff >= COORD_W'(d))
                        && ((hy_ff - COORD_W'(d)) < h_ext);
      end
      cmd_push = accept && !ignore;
      req_full = cmd_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pre_ff  <= '0;
         hx_ff   <= '0;
         hy_ff   <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pre_ff  <= pre_in;
         hx_ff   <= hx_in;
         hy_ff   <= hy_in;
         slot_ff <= slot_in;
      end
   end

endmodule

>>> rtl/core/sbb_back.sv
module sbb_back
   import sbb_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  logic [LEVEL_W-1:0] out_level,
   output logic               out_push,
   output res_type            out_data
);

   localparam int TAPS  = 2 * MAX_RADIUS + 1;
   localparam int SLOTS = 2 * MAX_RADIUS;
   localparam int SW    = $clog2(SLOTS);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int CW    = LEVEL_W + 1;

   logic [PIX_W-1:0]  window_ff [TAPS];
   cmd_type           c1_ff, c2_ff, c3_ff, c4_ff;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [PROD_W-1:0] hprod_ff [TAPS][3];
   logic [PROD_W-1:0] vprod_ff [TAPS][3];
   logic [PIX_W-1:0]  hres_ff, hres_c;
   logic [PIX_W-1:0]  rd_ff [SLOTS];
   logic [PIX_W-1:0]  vval [TAPS];
   logic [SUM_W-1:0]  hsum [3];
   logic [SUM_W-1:0]  vsum [3];
   coef_row_type      coefs;
   logic [4:0]        shift;
   logic [2:0]        inflight;
   logic [CW-1:0]     occupancy;
   logic [SLOT_W:0]   vslot [TAPS];

   always_comb begin
      coefs     = COEF_ROWS[cfg.radius];
      shift     = {1'b0, cfg.radius} << 1;
      inflight  = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);
      occupancy = CW'(out_level) + CW'(inflight);
      cmd_pop   = !cmd_empty && (occupancy < CW'(OUT_DEPTH));
      for (int ch = 0; ch < 3; ch++) begin
         hsum[ch] = '0;
         vsum[ch] = '0;
         for (int d = 0; d < TAPS; d++) begin
            hsum[ch] = hsum[ch] + SUM_W'(hprod_ff[d][ch]);
            vsum[ch] = vsum[ch] + SUM_W'(vprod_ff[d][ch]);
         end
         hres_c[8*ch +: 8] = 8'(hsum[ch] >> shift);
      end
      vval[0]  = hres_ff;
      vslot[0] = '0;
      for (int m = 1; m < TAPS; m++) begin
         vslot[m] = ({1'b0, c3_ff.slot} >= (SLOT_W+1)'(m))
                    ? {1'b0, c3_ff.slot} - (SLOT_W+1)'(m)
                    : {1'b0, c3_ff.slot} + (SLOT_W+1)'(SLOTS - m);
         vval[m]  = rd_ff[vslot[m][SW-1:0]];
      end
      out_push            = v4_ff && c4_ff.emit;
      out_data.frame_last = c4_ff.last;
      out_data.red        = 8'(vsum[0] >> shift);
      out_data.green      = 8'(vsum[1] >> shift);
      out_data.blue       = 8'(vsum[2] >> shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int d = 0; d < TAPS; d++) window_ff[d] <= '0;
      end else begin
         v1_ff <= cmd_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (cmd_pop) begin
            window_ff[0] <= cmd.pixel;
            for (int d = 1; d < TAPS; d++) window_ff[d] <= window_ff[d-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         c1_ff <= cmd;
      end
      c2_ff   <= c1_ff;
      c3_ff   <= c2_ff;
      c4_ff   <= c3_ff;
      hres_ff <= c2_ff.have_h ? hres_c : '0;
      for (int d = 0; d < TAPS; d++) begin
         for (int ch = 0; ch < 3; ch++) begin
            hprod_ff[d][ch] <= (c1_ff.have_h && c1_ff.hmask[d])
               ? PROD_W'(window_ff[d][8*ch +: 8]) * PROD_W'(coefs[d*COEF_W +: COEF_W])
               : '0;
            vprod_ff[d][ch] <= c3_ff.vmask[d]
               ? PROD_W'(vval[d][8*ch +: 8]) * PROD_W'(coefs[d*COEF_W +: COEF_W])
               : '0;
         end
      end
   end

   for (genvar b = 0; b < SLOTS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (v2_ff && c2_ff.have_h && (c2_ff.slot == SLOT_W'(b))) begin
            mem[c2_ff.hx[XW-1:0]] <= hres_c;
         end
         rd_ff[b] <= mem[c2_ff.hx[XW-1:0]];
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_level < LEVEL_W'(OUT_DEPTH)))
      else $error("result transfer into a full output queue");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      occupancy <= CW'(OUT_DEPTH))
      else $error("results in flight exceed output queue space");
   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> v1_ff)
      else $error("popped command did not enter the pipeline");
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && c4_ff.last) |-> out_push)
      else $error("frame end marked on an item with no result");
`endif

endmodule
